// ===== sv/hsvck_pkg.sv =====
// Shared types, widths and helper functions for the HSV chroma key pipeline.
// No dependencies; every other file in this folder refers to it by scoped names.
package hsvck_pkg;

	localparam int unsigned PixW     = 8;
	localparam int unsigned NumW     = 18;                 // dividend width
	localparam int unsigned DenW     = 9;                  // divisor, remainder, quotient width
	localparam int unsigned LowW     = NumW - DenW;        // dividend bits shifted in one per step
	localparam int unsigned DivSteps = LowW;               // one quotient bit per stage
	localparam int unsigned HpW      = 12;                 // hue numerator before scaling
	localparam int unsigned CfgIdxW  = 3;

	localparam logic [NumW-1:0] SatScale = NumW'(510);    // 2 * 255
	localparam logic [NumW-1:0] HueScale = NumW'(60);
	localparam logic [DenW-1:0] HueWrap  = DenW'(180);

	localparam logic [CfgIdxW-1:0] CFG_HUE_LOW  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_SAT_LOW  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_VAL_LOW  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_HUE_HIGH = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_SAT_HIGH = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_VAL_HIGH = 3'd5;

	typedef struct packed {
		logic [PixW-1:0] blue;
		logic [PixW-1:0] green;
		logic [PixW-1:0] red;
	} pix_t;

	// Data that rides along the divider untouched
	typedef struct packed {
		pix_t            fg;
		pix_t            bg;
		logic [PixW-1:0] val;
		logic            sat_zero;
		logic            hue_zero;
	} side_t;

	typedef struct packed {
		logic [NumW-1:0] num;
		logic [DenW-1:0] den;
	} divop_t;

	typedef struct packed {
		side_t  side;
		divop_t sat;
		divop_t hue;
	} prep_t;

	typedef struct packed {
		logic [LowW-1:0] low;
		logic [DenW-1:0] den;
		logic [DenW-1:0] rem;
		logic [DenW-1:0] quo;
	} divst_t;

	typedef struct packed {
		side_t           side;
		logic [DenW-1:0] sat_quo;
		logic [DenW-1:0] hue_quo;
	} divres_t;

	// Quotient fits in DenW bits, so the upper dividend bits already sit below the divisor.
	function automatic divst_t div_init(input divop_t op);
		divst_t s;
		s.low = op.num[LowW-1:0];
		s.rem = op.num[NumW-1:LowW];
		s.den = op.den;
		s.quo = '0;
		return s;
	endfunction

	// One restoring step: bring down the next dividend bit, subtract if it fits.
	function automatic divst_t div_step(input divst_t s);
		divst_t        n;
		logic [DenW:0] t;
		logic          ge;
		t     = {s.rem, s.low[LowW-1]};
		ge    = (t >= {1'b0, s.den});
		n.low = {s.low[LowW-2:0], 1'b0};
		n.den = s.den;
		n.rem = ge ? DenW'(t - {1'b0, s.den}) : t[DenW-1:0];
		n.quo = {s.quo[DenW-2:0], ge};
		return n;
	endfunction

endpackage

// ===== sv/hsvck_if.sv =====
// Channel interfaces for the HSV chroma key: pixel input, pixel output, register writes.
// Depends on hsvck_pkg for field widths.
interface hsvck_in_if;
	logic                           valid;
	logic                           ready;
	logic [hsvck_pkg::PixW-1:0]     fg_blue;
	logic [hsvck_pkg::PixW-1:0]     fg_green;
	logic [hsvck_pkg::PixW-1:0]     fg_red;
	logic [hsvck_pkg::PixW-1:0]     bg_blue;
	logic [hsvck_pkg::PixW-1:0]     bg_green;
	logic [hsvck_pkg::PixW-1:0]     bg_red;

	modport source(output valid, fg_blue, fg_green, fg_red, bg_blue, bg_green, bg_red,
		input ready);
	modport sink(input valid, fg_blue, fg_green, fg_red, bg_blue, bg_green, bg_red,
		output ready);
endinterface

interface hsvck_out_if;
	logic                           valid;
	logic                           ready;
	logic [hsvck_pkg::PixW-1:0]     out_blue;
	logic [hsvck_pkg::PixW-1:0]     out_green;
	logic [hsvck_pkg::PixW-1:0]     out_red;
	logic                           keyed;

	modport source(output valid, out_blue, out_green, out_red, keyed, input ready);
	modport sink(input valid, out_blue, out_green, out_red, keyed, output ready);
endinterface

interface hsvck_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hsvck_pkg::CfgIdxW-1:0]  index;
	logic [hsvck_pkg::PixW-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/hsvck_prep.sv =====
// Front end of the key pipeline: max/min, hue sector, numerators and divisors (3 stages).
// Depends on hsvck_pkg.
module hsvck_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsvck_pkg::pix_t     fg,
	input  hsvck_pkg::pix_t     bg,
	output logic                out_valid,
	input  logic                out_ready,
	output hsvck_pkg::prep_t    out_op
);

	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	logic valid_s1, valid_s2, valid_s3;
	logic en_s1, en_s2, en_s3;

	hsvck_pkg::pix_t                fg_s1, bg_s1, fg_s2, bg_s2;
	logic [hsvck_pkg::PixW-1:0]     mx_s1, mn_s1, mx_s2, d_s2;
	logic [1:0]                     sel_s1;
	logic [hsvck_pkg::HpW-1:0]      hp_s2;
	hsvck_pkg::prep_t               op_s3;

	logic [hsvck_pkg::PixW-1:0]     mx_c, mn_c, d_c;
	logic [1:0]                     sel_c;
	logic [hsvck_pkg::HpW-1:0]      hp_c;
	hsvck_pkg::prep_t               op_c;

	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// Stage 1: extremes and the first maximal channel in red, green, blue order
	always_comb begin
		mx_c = fg.red;
		mn_c = fg.red;
		if (fg.green > mx_c) mx_c = fg.green;
		if (fg.blue > mx_c) mx_c = fg.blue;
		if (fg.green < mn_c) mn_c = fg.green;
		if (fg.blue < mn_c) mn_c = fg.blue;
		priority if (fg.red >= fg.green && fg.red >= fg.blue) begin
			sel_c = SEL_RED;
		end else if (fg.green >= fg.blue) begin
			sel_c = SEL_GREEN;
		end else begin
			sel_c = SEL_BLUE;
		end
	end

	// Stage 2: chroma and the hue numerator offset by six sectors to stay positive
	always_comb begin
		d_c = mx_s1 - mn_s1;
		unique case (sel_s1)
			SEL_RED: begin
				hp_c = hsvck_pkg::HpW'(fg_s1.green) + hsvck_pkg::HpW'(d_c) * 12'd6
					- hsvck_pkg::HpW'(fg_s1.blue);
			end
			SEL_GREEN: begin
				hp_c = hsvck_pkg::HpW'(fg_s1.blue) + hsvck_pkg::HpW'(d_c) * 12'd8
					- hsvck_pkg::HpW'(fg_s1.red);
			end
			SEL_BLUE: begin
				hp_c = hsvck_pkg::HpW'(fg_s1.red) + hsvck_pkg::HpW'(d_c) * 12'd10
					- hsvck_pkg::HpW'(fg_s1.green);
			end
			default: begin
				hp_c = '0;
			end
		endcase
	end

	// Stage 3: rounded-division operands
	always_comb begin
		op_c.side.fg       = fg_s2;
		op_c.side.bg       = bg_s2;
		op_c.side.val      = mx_s2;
		op_c.side.sat_zero = (mx_s2 == '0);
		op_c.side.hue_zero = (d_s2 == '0);
		op_c.sat.num = hsvck_pkg::NumW'(d_s2) * hsvck_pkg::SatScale
			+ hsvck_pkg::NumW'(mx_s2);
		op_c.sat.den = {mx_s2, 1'b0};
		op_c.hue.num = hsvck_pkg::NumW'(hp_s2) * hsvck_pkg::HueScale
			+ hsvck_pkg::NumW'(d_s2);
		op_c.hue.den = {d_s2, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			fg_s1  <= fg;
			bg_s1  <= bg;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sel_s1 <= sel_c;
		end
		if (en_s2 && valid_s1) begin
			fg_s2 <= fg_s1;
			bg_s2 <= bg_s1;
			mx_s2 <= mx_s1;
			d_s2  <= d_c;
			hp_s2 <= hp_c;
		end
		if (en_s3 && valid_s2) begin
			op_s3 <= op_c;
		end
	end

	assign out_valid = valid_s3;
	assign out_op    = op_s3;

	// Offset hue numerator must land in [5d, 11d] for a nonzero chroma
	a_hp_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && d_s2 != '0 |->
			hp_s2 >= hsvck_pkg::HpW'(d_s2) * 12'd5 &&
			hp_s2 <= hsvck_pkg::HpW'(d_s2) * 12'd11)
		else $error("hue numerator outside its sector range");

endmodule

// ===== sv/hsvck_div.sv =====
// Pipelined restoring divider pair for saturation and hue, one quotient bit per stage.
// Depends on hsvck_pkg (types, div_init, div_step).
module hsvck_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsvck_pkg::prep_t    in_op,
	output logic                out_valid,
	input  logic                out_ready,
	output hsvck_pkg::divres_t  out_res
);

	localparam int unsigned Last = hsvck_pkg::DivSteps - 1;

	logic                   valid_sk [hsvck_pkg::DivSteps];
	logic                   en_sk    [hsvck_pkg::DivSteps];
	hsvck_pkg::side_t       side_sk  [hsvck_pkg::DivSteps];
	hsvck_pkg::divst_t      sat_sk   [hsvck_pkg::DivSteps];
	hsvck_pkg::divst_t      hue_sk   [hsvck_pkg::DivSteps];

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		en_sk[Last] = !valid_sk[Last] || out_ready;
		for (int k = Last - 1; k >= 0; k--) begin
			en_sk[k] = !valid_sk[k] || en_sk[k+1];
		end
	end

	assign in_ready = en_sk[0];

	for (genvar k = 0; k < hsvck_pkg::DivSteps; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_sk[k] <= 1'b0;
				end else if (en_sk[k]) begin
					valid_sk[k] <= in_valid;
				end
			end

			always_ff @(posedge clk) begin
				if (en_sk[k] && in_valid) begin
					side_sk[k] <= in_op.side;
					sat_sk[k]  <= hsvck_pkg::div_step(hsvck_pkg::div_init(in_op.sat));
					hue_sk[k]  <= hsvck_pkg::div_step(hsvck_pkg::div_init(in_op.hue));
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_sk[k] <= 1'b0;
				end else if (en_sk[k]) begin
					valid_sk[k] <= valid_sk[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en_sk[k] && valid_sk[k-1]) begin
					side_sk[k] <= side_sk[k-1];
					sat_sk[k]  <= hsvck_pkg::div_step(sat_sk[k-1]);
					hue_sk[k]  <= hsvck_pkg::div_step(hue_sk[k-1]);
				end
			end
		end
	end

	assign out_valid       = valid_sk[Last];
	assign out_res.side    = side_sk[Last];
	assign out_res.sat_quo = sat_sk[Last].quo;
	assign out_res.hue_quo = hue_sk[Last].quo;

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sk[0] && !side_sk[0].sat_zero |-> sat_sk[0].rem < sat_sk[0].den)
		else $error("saturation remainder not below divisor");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sk[Last] && !side_sk[Last].sat_zero |-> sat_sk[Last].quo <= 9'd255)
		else $error("saturation quotient above 255");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_sk[Last] && !side_sk[Last].hue_zero |->
			hue_sk[Last].quo >= 9'd150 && hue_sk[Last].quo <= 9'd330)
		else $error("offset hue quotient outside its range");

endmodule

// ===== sv/hsv_chroma_key_pixel.sv =====
// HSV chroma key, one foreground/background pixel pair per transaction.
// Pipeline: 13 register stages (3 front-end, 9 divider, 1 compare/select); throughput one
// pixel per cycle while pixel_out.ready stays high. The nine-stage restoring dividers make
// up most of the pipeline.
// Reset clears all valid bits and the six key bounds to 0; the register port is always ready.
// Depends on hsvck_pkg, hsvck_if, hsvck_prep and hsvck_div.
module hsv_chroma_key_pixel (
	input  logic            clk,
	input  logic            arst_n,
	hsvck_in_if.sink        pixel_in,
	hsvck_out_if.source     pixel_out,
	hsvck_cfg_if.sink       cfg
);

	logic [hsvck_pkg::PixW-1:0] hue_low_q, sat_low_q, val_low_q;
	logic [hsvck_pkg::PixW-1:0] hue_high_q, sat_high_q, val_high_q;

	hsvck_pkg::pix_t    fg_in, bg_in;
	hsvck_pkg::prep_t   prep_op;
	hsvck_pkg::divres_t div_res;
	logic               prep_valid, prep_ready;
	logic               div_valid, div_ready;

	logic [hsvck_pkg::PixW-1:0] hue_c, sat_c;
	logic                       key_c;
	logic                       valid_s13, en_s13;
	hsvck_pkg::pix_t            pix_s13;
	logic                       keyed_s13;

	assign cfg.ready = 1'b1;

	// Out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_low_q  <= '0;
			sat_low_q  <= '0;
			val_low_q  <= '0;
			hue_high_q <= '0;
			sat_high_q <= '0;
			val_high_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hsvck_pkg::CFG_HUE_LOW:  hue_low_q  <= cfg.data;
				hsvck_pkg::CFG_SAT_LOW:  sat_low_q  <= cfg.data;
				hsvck_pkg::CFG_VAL_LOW:  val_low_q  <= cfg.data;
				hsvck_pkg::CFG_HUE_HIGH: hue_high_q <= cfg.data;
				hsvck_pkg::CFG_SAT_HIGH: sat_high_q <= cfg.data;
				hsvck_pkg::CFG_VAL_HIGH: val_high_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign fg_in.blue  = pixel_in.fg_blue;
	assign fg_in.green = pixel_in.fg_green;
	assign fg_in.red   = pixel_in.fg_red;
	assign bg_in.blue  = pixel_in.bg_blue;
	assign bg_in.green = pixel_in.bg_green;
	assign bg_in.red   = pixel_in.bg_red;

	hsvck_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_in.valid),
		.in_ready  (pixel_in.ready),
		.fg        (fg_in),
		.bg        (bg_in),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.out_op    (prep_op)
	);

	hsvck_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.in_op     (prep_op),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.out_res   (div_res)
	);

	// Undo the six-sector offset: quotients of 180 and up wrap back down
	always_comb begin
		if (div_res.side.hue_zero) begin
			hue_c = '0;
		end else if (div_res.hue_quo >= hsvck_pkg::HueWrap) begin
			hue_c = hsvck_pkg::PixW'(div_res.hue_quo - hsvck_pkg::HueWrap);
		end else begin
			hue_c = div_res.hue_quo[hsvck_pkg::PixW-1:0];
		end
		sat_c = div_res.side.sat_zero ? '0 : div_res.sat_quo[hsvck_pkg::PixW-1:0];
		key_c = hue_c >= hue_low_q && hue_c <= hue_high_q &&
			sat_c >= sat_low_q && sat_c <= sat_high_q &&
			div_res.side.val >= val_low_q && div_res.side.val <= val_high_q;
	end

	assign en_s13    = !valid_s13 || pixel_out.ready;
	assign div_ready = en_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s13 <= 1'b0;
		end else if (en_s13) begin
			valid_s13 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s13 && div_valid) begin
			pix_s13   <= key_c ? div_res.side.bg : div_res.side.fg;
			keyed_s13 <= key_c;
		end
	end

	assign pixel_out.valid     = valid_s13;
	assign pixel_out.out_blue  = pix_s13.blue;
	assign pixel_out.out_green = pix_s13.green;
	assign pixel_out.out_red   = pix_s13.red;
	assign pixel_out.keyed     = keyed_s13;

endmodule
